// ===== rtl/elev_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator controller package
// Position codes, command codes and the item and result layouts shared by the
// controller, its call queue and the channel interfaces.
// ----------------------------------------------------------------------------
package elev_pkg;

  localparam int FLOORS  = 4;
  localparam int POS_W   = 3;
  localparam int FLOOR_W = 2;

  // Position codes above the floors.
  localparam logic [POS_W-1:0] POS_NONE  = POS_W'(FLOORS);
  localparam logic [POS_W-1:0] POS_ERROR = POS_W'(FLOORS + 1);
  localparam logic [POS_W-1:0] POS_TEST  = POS_W'(FLOORS + 2);

  localparam logic [1:0] DOOR_CMD_NONE  = 2'd0;
  localparam logic [1:0] DOOR_CMD_CLOSE = 2'd1;
  localparam logic [1:0] DOOR_CMD_OPEN  = 2'd2;

  localparam logic [1:0] MOTOR_IDLE      = 2'd0;
  localparam logic [1:0] MOTOR_CALIBRATE = 2'd1;
  localparam logic [1:0] MOTOR_FAST      = 2'd2;

  localparam logic [1:0] SENSE_CLOSED = 2'd0;
  localparam logic [1:0] SENSE_OPEN   = 2'd1;

  typedef struct packed {
    logic [2:0] cabin_pos;
    logic [1:0] door_sense;
    logic [2:0] pressed_floor;
    logic       from_cabin;
  } item_t;

  typedef struct packed {
    logic [1:0] door_cmd;
    logic [1:0] motor_cmd;
    logic       move_up;
    logic       set_cabin_ind;
    logic       set_hall_ind;
    logic [1:0] set_ind_floor;
    logic       clear_ind;
    logic [1:0] clear_ind_floor;
    logic       display_show;
    logic [2:0] display_value;
    logic [2:0] ctrl_state;
  } result_t;

  // Controller to queue.
  typedef struct packed {
    logic               take_req;
    logic               add_req;
    logic [FLOOR_W-1:0] add_floor;
    logic [POS_W-1:0]   target;
  } queue_req_t;

  // Queue to controller.
  typedef struct packed {
    logic             not_empty;
    logic [POS_W-1:0] head;
    logic             add_ok;
  } queue_stat_t;

endpackage

// ===== rtl/elev_chan_if.sv =====
// ----------------------------------------------------------------------------
// Elevator controller channels
// Valid/ready channels for input items and for result words.
// ----------------------------------------------------------------------------
interface elev_item_if;
  import elev_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface elev_result_if;
  import elev_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/elev_call_queue.sv =====
// ----------------------------------------------------------------------------
// Elevator call queue
// Ring of call slots with a wrap flag. Takes the oldest call and adds a new
// one in the same tick; duplicates of queued or targeted floors are dropped.
// ----------------------------------------------------------------------------
module elev_call_queue import elev_pkg::*; #(
  parameter int DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  queue_req_t  req,
  output queue_stat_t stat
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [POS_W-1:0] slots      [DEPTH];
  logic [POS_W-1:0] slots_next [DEPTH];
  logic [IDX_W-1:0] rd, rd_next;
  logic [IDX_W-1:0] wr, wr_next;
  logic             wrapped, wrapped_next;

  logic             not_empty, take, rd_wrap, wr_wrap;
  logic             full_after, dup, add_ok, store;
  logic [POS_W-1:0] target_after, add_pos;

  always_comb begin
    not_empty    = (rd != wr) || wrapped;
    take         = req.take_req && not_empty;
    rd_wrap      = (rd == LAST_IDX);
    wr_wrap      = (wr == LAST_IDX);
    slots_next   = slots;
    rd_next      = rd;
    wr_next      = wr;
    wrapped_next = wrapped;

    if (take) begin
      slots_next[rd] = POS_NONE;
      rd_next        = rd_wrap ? '0 : rd + 1'b1;
      if (rd_wrap) begin
        wrapped_next = 1'b0;
      end
    end

    // The add sees the queue and the target as they stand after the take.
    full_after   = (rd_next == wr) && wrapped_next;
    target_after = take ? slots[rd] : req.target;
    add_pos      = POS_W'(req.add_floor);
    dup          = (add_pos == target_after);
    for (int i = 0; i < DEPTH; i++) begin
      if (slots_next[i] == add_pos) begin
        dup = 1'b1;
      end
    end
    add_ok = req.add_req && !full_after;
    store  = add_ok && !dup;

    if (store) begin
      slots_next[wr] = add_pos;
      wr_next        = wr_wrap ? '0 : wr + 1'b1;
      if (wr_wrap) begin
        wrapped_next = 1'b1;
      end
    end
  end

  assign stat.not_empty = not_empty;
  assign stat.head      = slots[rd];
  assign stat.add_ok    = add_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slots[i] <= POS_NONE;
      end
      rd      <= '0;
      wr      <= '0;
      wrapped <= 1'b0;
    end else if (en) begin
      slots   <= slots_next;
      rd      <= rd_next;
      wr      <= wr_next;
      wrapped <= wrapped_next;
    end
  end

`ifndef SYNTHESIS
  logic [DEPTH-1:0] live;
  logic [CNT_W-1:0] occupancy;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i] = (slots[i] != POS_NONE);
    end
    occupancy = wrapped ? CNT_W'(DEPTH) - CNT_W'(rd) + CNT_W'(wr)
                        : CNT_W'(wr) - CNT_W'(rd);
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (rd <= LAST_IDX) && (wr <= LAST_IDX))
    else $error("call queue pointer out of range");

  // Only queued calls hold a floor; every other slot holds the none marker.
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    $countones(live) == int'(occupancy))
    else $error("call queue slot contents disagree with pointers");

  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (rd == wr) && wrapped && !take |=> wr == $past(wr))
    else $error("call queue written while full");
`endif

endmodule

// ===== rtl/elev_ctrl.sv =====
// ----------------------------------------------------------------------------
// Elevator controller sequencer
// Six-phase door and motor sequencer with cabin position tracking, display
// and call indicator commands.
// ----------------------------------------------------------------------------
module elev_ctrl import elev_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  item_t       item,
  input  queue_stat_t stat,
  output queue_req_t  req,
  output result_t     result
);

  typedef enum logic [2:0] {
    PH_UNINIT  = 3'd0,
    PH_WAIT    = 3'd1,
    PH_CLOSE   = 3'd2,
    PH_MOVE    = 3'd3,
    PH_OPEN    = 3'd4,
    PH_TROUBLE = 3'd5
  } phase_t;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] target, target_next;
  logic [POS_W-1:0] last_pos, shown_pos;
  logic             going_up, going_up_next;
  logic             add_ok;

  always_comb begin
    phase_next    = phase;
    target_next   = target;
    going_up_next = going_up;
    shown_pos     = last_pos;
    result        = '0;

    unique case (phase)
      PH_UNINIT: begin
        if (item.cabin_pos != '0) begin
          result.motor_cmd = MOTOR_CALIBRATE;
        end else begin
          phase_next = PH_OPEN;
          shown_pos  = '0;
        end
      end
      PH_WAIT: begin
        if (stat.not_empty) begin
          target_next   = stat.head;
          going_up_next = (stat.head > last_pos);
          phase_next    = PH_CLOSE;
        end
      end
      PH_CLOSE: begin
        if (item.door_sense != SENSE_CLOSED) begin
          result.door_cmd = DOOR_CMD_CLOSE;
        end else begin
          phase_next = PH_MOVE;
        end
      end
      PH_MOVE: begin
        if (last_pos != target) begin
          result.motor_cmd = MOTOR_FAST;
        end else begin
          phase_next = PH_OPEN;
        end
      end
      PH_OPEN: begin
        result.door_cmd = DOOR_CMD_OPEN;
        if (item.door_sense == SENSE_OPEN) begin
          phase_next = PH_WAIT;
          if (last_pos < POS_NONE) begin
            result.clear_ind       = 1'b1;
            result.clear_ind_floor = last_pos[FLOOR_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase

    if (shown_pos < POS_NONE || shown_pos == POS_ERROR || shown_pos == POS_TEST) begin
      result.display_show  = 1'b1;
      result.display_value = shown_pos;
    end

    add_ok = stat.add_ok;
    if (add_ok) begin
      result.set_cabin_ind = item.from_cabin;
      result.set_hall_ind  = !item.from_cabin;
      result.set_ind_floor = item.pressed_floor[FLOOR_W-1:0];
    end

    result.move_up    = going_up_next;
    result.ctrl_state = phase_next;
  end

  // Buttons are checked against the position reported in this tick.
  assign req.take_req  = (phase == PH_WAIT);
  assign req.add_req   = (item.pressed_floor < POS_NONE) &&
                         (item.pressed_floor != item.cabin_pos);
  assign req.add_floor = item.pressed_floor[FLOOR_W-1:0];
  assign req.target    = target;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_UNINIT;
      target   <= POS_NONE;
      last_pos <= POS_NONE;
      going_up <= 1'b0;
    end else if (en) begin
      phase    <= phase_next;
      target   <= target_next;
      last_pos <= item.cabin_pos;
      going_up <= going_up_next;
    end
  end

endmodule

// ===== rtl/elevator_controller_with_call_queue.sv =====
// ----------------------------------------------------------------------------
// Elevator controller with call queue
// Per-tick elevator sequencer with a ring queue of floor calls.
//
//   Channel   Direction  Word contents
//   items     in         cabin_pos, door_sense, pressed_floor, from_cabin
//   results   out        door, motor, direction, indicator, display, state
//
// One word is taken per cycle while no result stalls, and each one yields exactly one result word.
// A word waits in the input register; its result enters the output register
// when the word advances and can be taken from there.
// The controller state and the call queue update in the cycle a word moves
// from the input register to the output register.
// Reset leaves the controller uninitialized and the call queue empty.
// A stalled result holds both registers; items.ready falls only then.
// ----------------------------------------------------------------------------
module elevator_controller_with_call_queue import elev_pkg::*; #(
  parameter int QUEUE_DEPTH = 3
) (
  input logic          clk,
  input logic          rst,
  elev_item_if.sink    items,
  elev_result_if.source results
);

  logic        s1_valid;
  item_t       s1_item;
  logic        res_valid;
  result_t     res_item;
  logic        advance;
  logic        in_ready;
  result_t     result;
  queue_req_t  q_req;
  queue_stat_t q_stat;

  assign advance       = s1_valid && (!res_valid || results.ready);
  assign in_ready      = !s1_valid || advance;
  assign items.ready   = in_ready;
  assign results.valid = res_valid;
  assign results.data  = res_item;

  elev_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (s1_item),
    .stat   (q_stat),
    .req    (q_req),
    .result (result)
  );

  elev_call_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .req  (q_req),
    .stat (q_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= items.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && in_ready) begin
      s1_item <= items.data;
    end
    if (advance) begin
      res_item <= result;
    end
  end

`ifndef SYNTHESIS
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && (s1_item == $past(s1_item)))
    else $error("input register lost a word while stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input not ready although the input register is empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("processed word produced no result");
`endif

endmodule

// ===== verif/elev_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Elevator controller scoreboard
// Cycle-free predictor of the controller and its call queue. It keeps the
// expected result words in order and checks each one as it arrives.
// ----------------------------------------------------------------------------
package elev_tb_pkg;
  import elev_pkg::*;

  localparam int CALL_DEPTH = 3;

  // Door sense codes that the package leaves unnamed.
  localparam logic [1:0] SENSE_MOVING = 2'd2;
  localparam logic [1:0] SENSE_BAD    = 2'd3;

  typedef enum logic [2:0] {
    ST_UNINIT  = 3'd0,
    ST_WAITING = 3'd1,
    ST_CLOSING = 3'd2,
    ST_MOVING  = 3'd3,
    ST_OPENING = 3'd4,
    ST_TROUBLE = 3'd5
  } ctrl_phase_e;

  class elevator_scoreboard;
    ctrl_phase_e phase;
    logic [2:0]  target_floor;
    logic [2:0]  last_pos;
    logic        going_up;
    logic [2:0]  call_slots [CALL_DEPTH];
    int          read_slot;
    int          write_slot;
    bit          wrapped;

    result_t     expected_results [$];
    int          accepted_items;
    int          results_seen;
    int          errors;

    function new();
      phase        = ST_UNINIT;
      target_floor = POS_NONE;
      last_pos     = POS_NONE;
      going_up     = 1'b0;
      foreach (call_slots[i]) call_slots[i] = POS_NONE;
      read_slot      = 0;
      write_slot     = 0;
      wrapped        = 1'b0;
      accepted_items = 0;
      results_seen   = 0;
      errors         = 0;
    endfunction

    // Full is refused before anything else; a floor that is already the
    // target or already waiting counts as taken without a second slot.
    function bit add_call(logic [2:0] fl);
      if (read_slot == write_slot && wrapped) return 1'b0;
      if (fl == target_floor) return 1'b1;
      foreach (call_slots[i]) if (call_slots[i] == fl) return 1'b1;
      call_slots[write_slot] = fl;
      write_slot++;
      if (write_slot >= CALL_DEPTH) begin
        write_slot = 0;
        wrapped    = 1'b1;
      end
      return 1'b1;
    endfunction

    function bit take_call();
      if (read_slot == write_slot && !wrapped) return 1'b0;
      target_floor = call_slots[read_slot];
      going_up     = (target_floor > last_pos);
      call_slots[read_slot] = POS_NONE;
      read_slot++;
      if (read_slot >= CALL_DEPTH) begin
        read_slot = 0;
        wrapped   = 1'b0;
      end
      return 1'b1;
    endfunction

    function result_t tick(item_t it);
      result_t r;
      r = '0;
      case (phase)
        ST_UNINIT: begin
          if (it.cabin_pos != 3'd0) begin
            r.motor_cmd = MOTOR_CALIBRATE;
          end else begin
            phase    = ST_OPENING;
            last_pos = it.cabin_pos;
          end
        end
        ST_WAITING: begin
          if (take_call()) phase = ST_CLOSING;
        end
        ST_CLOSING: begin
          if (it.door_sense != SENSE_CLOSED) r.door_cmd = DOOR_CMD_CLOSE;
          else phase = ST_MOVING;
        end
        ST_MOVING: begin
          if (last_pos != target_floor) r.motor_cmd = MOTOR_FAST;
          else phase = ST_OPENING;
        end
        ST_OPENING: begin
          r.door_cmd = DOOR_CMD_OPEN;
          if (it.door_sense == SENSE_OPEN) begin
            phase = ST_WAITING;
            if (last_pos < FLOORS) begin
              r.clear_ind       = 1'b1;
              r.clear_ind_floor = last_pos[1:0];
            end
          end
        end
        default: ;
      endcase

      // Except on leaving calibration, the display still shows where the cabin was before this word.
      if (last_pos < FLOORS || last_pos == POS_ERROR || last_pos == POS_TEST) begin
        r.display_show  = 1'b1;
        r.display_value = last_pos;
      end

      last_pos = it.cabin_pos;

      if (it.pressed_floor < FLOORS && it.pressed_floor != last_pos) begin
        if (add_call(it.pressed_floor)) begin
          r.set_cabin_ind = it.from_cabin;
          r.set_hall_ind  = ~it.from_cabin;
          r.set_ind_floor = it.pressed_floor[1:0];
        end
      end

      r.move_up    = going_up;
      r.ctrl_state = phase;
      return r;
    endfunction

    function void note_input(item_t it);
      expected_results.push_back(tick(it));
      accepted_items++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [3:0] got_v, logic [3:0] want_v);
      if (got_v !== want_v)
        report($sformatf("word %0d %s: got %0d, expected %0d",
                         results_seen, name, got_v, want_v));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      want = expected_results.pop_front();
      results_seen++;
      check_field("door_cmd", 4'(got.door_cmd), 4'(want.door_cmd));
      check_field("motor_cmd", 4'(got.motor_cmd), 4'(want.motor_cmd));
      check_field("move_up", 4'(got.move_up), 4'(want.move_up));
      check_field("set_cabin_ind", 4'(got.set_cabin_ind), 4'(want.set_cabin_ind));
      check_field("set_hall_ind", 4'(got.set_hall_ind), 4'(want.set_hall_ind));
      check_field("set_ind_floor", 4'(got.set_ind_floor), 4'(want.set_ind_floor));
      check_field("clear_ind", 4'(got.clear_ind), 4'(want.clear_ind));
      check_field("clear_ind_floor", 4'(got.clear_ind_floor),
                  4'(want.clear_ind_floor));
      check_field("display_show", 4'(got.display_show), 4'(want.display_show));
      check_field("display_value", 4'(got.display_value), 4'(want.display_value));
      check_field("ctrl_state", 4'(got.ctrl_state), 4'(want.ctrl_state));
    endtask
  endclass

endpackage

// ===== verif/tb_elevator_controller_with_call_queue.sv =====
// ----------------------------------------------------------------------------
// Elevator controller testbench
// Drives a directed walk through every controller phase but trouble and then random
// ticks, mostly following a plausible cabin and door, against the scoreboard
// predictor, with bursty input, a stalling receiver and one long back-pressure.
// ----------------------------------------------------------------------------
module tb_elevator_controller_with_call_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import elev_pkg::*;
  import elev_tb_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AFTER   = 600;
  localparam int HOLD_CYCLES  = 400;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  elev_item_if   items_ch ();
  elev_result_if results_ch ();

  elevator_controller_with_call_queue #(.QUEUE_DEPTH(CALL_DEPTH)) DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  elevator_scoreboard sb = new();
  int burst_left;

  always #10 clk = ~clk;

  function automatic item_t tick_word(int cab, int door, int pr, int fc);
    item_t it;
    it.cabin_pos     = 3'(cab);
    it.door_sense    = 2'(door);
    it.pressed_floor = 3'(pr);
    it.from_cabin    = 1'(fc);
    return it;
  endfunction

  // Mostly follows what a real cabin and door would report in the current
  // phase, so that the controller keeps cycling through its trips.
  function automatic item_t make_random_item();
    item_t it;
    int    r;
    it.from_cabin = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 40) it.pressed_floor = POS_NONE;
    else if (r < 46) it.pressed_floor = 3'($urandom_range(FLOORS + 1, 7));
    else it.pressed_floor = 3'($urandom_range(0, FLOORS - 1));

    if ($urandom_range(0, 99) < 12) begin
      it.cabin_pos  = 3'($urandom_range(0, 7));
      it.door_sense = 2'($urandom_range(0, 3));
      return it;
    end

    it.cabin_pos  = (sb.last_pos < FLOORS) ? sb.last_pos
                                           : 3'($urandom_range(0, FLOORS - 1));
    it.door_sense = SENSE_OPEN;
    case (sb.phase)
      ST_UNINIT: begin
        it.cabin_pos  = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        it.door_sense = SENSE_CLOSED;
      end
      ST_CLOSING: begin
        it.door_sense = ($urandom_range(0, 2) == 0) ? SENSE_CLOSED
                                                    : 2'($urandom_range(1, 2));
      end
      ST_MOVING: begin
        it.door_sense = SENSE_CLOSED;
        r = $urandom_range(0, 2);
        if (r == 0) it.cabin_pos = sb.target_floor;
        else if (r == 1) it.cabin_pos = POS_NONE;
        else it.cabin_pos = 3'($urandom_range(0, FLOORS - 1));
      end
      ST_OPENING: begin
        it.door_sense = ($urandom_range(0, 2) == 0) ? SENSE_OPEN
                                                    : 2'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return it;
  endfunction

  // Offers one word and returns once it is taken. Valid stays high across
  // consecutive words of a burst and only drops for a real gap.
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    items_ch.valid <= 1'b1;
    items_ch.data  <= it;
    do @(posedge clk); while (items_ch.ready !== 1'b1);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic run_directed();
    // Calibration from odd positions, with a call taken while uninitialized.
    send_item(tick_word(POS_ERROR, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(POS_TEST, SENSE_BAD, 7, 1));
    send_item(tick_word(7, SENSE_CLOSED, 2, 1));
    send_item(tick_word(POS_NONE, SENSE_CLOSED, POS_NONE, 0));
    // Reaching floor 0; a button for the current floor is ignored.
    send_item(tick_word(0, SENSE_CLOSED, 0, 0));
    send_item(tick_word(0, SENSE_MOVING, 3, 0));
    send_item(tick_word(0, SENSE_BAD, 1, 1));
    // Queue is full now, so even a floor already waiting is refused.
    send_item(tick_word(0, SENSE_OPEN, 2, 0));
    send_item(tick_word(0, SENSE_OPEN, POS_NONE, 0));
    // Calls for the target and for a queued floor are lit but not stored.
    send_item(tick_word(0, SENSE_OPEN, 2, 1));
    send_item(tick_word(0, SENSE_MOVING, 3, 1));
    send_item(tick_word(0, SENSE_CLOSED, 0, 0));
    send_item(tick_word(POS_NONE, SENSE_CLOSED, 0, 1));
    send_item(tick_word(1, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(2, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(2, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(2, SENSE_OPEN, 1, 0));
    send_item(tick_word(2, SENSE_OPEN, POS_NONE, 1));
    send_item(tick_word(2, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(POS_ERROR, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(3, SENSE_CLOSED, POS_NONE, 0));
    send_item(tick_word(3, SENSE_CLOSED, POS_NONE, 0));
    // Door opens while the cabin reads between floors: no clear is given.
    send_item(tick_word(POS_NONE, SENSE_MOVING, POS_NONE, 0));
    send_item(tick_word(POS_NONE, SENSE_OPEN, POS_NONE, 0));
    send_item(tick_word(POS_NONE, SENSE_OPEN, POS_NONE, 0));
  endtask

  initial begin : stimulus
    items_ch.valid = 1'b0;
    items_ch.data  = '0;
    burst_left     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    repeat (RANDOM_ITEMS) send_item(make_random_item());
    items_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_elevator_controller_with_call_queue: done, clean");
    end else begin
      $display("tb_elevator_controller_with_call_queue: done, errors");
    end
    $finish;
  end

  // Result side: checks each taken word, then picks the next ready value.
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         tick_cnt;
    bit         hold_done;
    results_ch.ready = 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick_cnt  = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_ch.valid === 1'b1 && results_ch.ready === 1'b1)
        sb.check_result(results_ch.data);
      if (!hold_done && sb.accepted_items >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        tick_cnt++;
        case (mode)
          SINK_OPEN:     results_ch.ready <= 1'b1;
          SINK_RANDOM:   results_ch.ready <= ($urandom_range(0, 99) < 55);
          SINK_PERIODIC: results_ch.ready <= ((tick_cnt % 5) != 0);
          default:       results_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (items_ch.valid === 1'b1 && items_ch.ready === 1'b1) ||
          (results_ch.valid === 1'b1 && results_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_elevator_controller_with_call_queue: done, errors");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
rtl/elev_pkg.sv
rtl/elev_chan_if.sv
rtl/elev_call_queue.sv
rtl/elev_ctrl.sv
rtl/elevator_controller_with_call_queue.sv
verif/elev_tb_pkg.sv
verif/tb_elevator_controller_with_call_queue.sv
